[sv/fit_strategy_block_allocator_defines.svh]
// Assertion macros for the fit strategy block allocator.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef FIT_STRATEGY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_STRATEGY_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FSBA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/fsba_pkg.sv]
// Shared constants and types of the fit strategy block allocator.
// No dependencies; used by the interfaces, the cell and the top level.
package fsba_pkg;

   localparam int FREE_ENTRIES = 64;
   localparam int ADDR_BITS    = 16;
   localparam int IDX_W        = $clog2(FREE_ENTRIES);
   localparam int LEN_W        = ADDR_BITS + 1;

   localparam logic [LEN_W-1:0] ADDR_SPACE = {1'b1, {ADDR_BITS{1'b0}}};

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_HEAP = 2'd1;
   localparam logic [1:0] ST_OOM  = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic CSR_FIT   = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   typedef struct packed {
      logic                 vld;
      logic                 act;
      logic [ADDR_BITS-1:0] size;
      logic [ADDR_BITS-1:0] addr;
      logic [LEN_W-1:0]     end_a;
      logic [1:0]           strat;
      logic                 bfound;
      logic [IDX_W-1:0]     bidx;
      logic [ADDR_BITS-1:0] bbase;
      logic [LEN_W-1:0]     blen;
      logic                 lfound;
      logic [IDX_W-1:0]     lidx;
      logic [ADDR_BITS-1:0] lbase;
      logic [LEN_W-1:0]     llen;
      logic                 rfound;
      logic [IDX_W-1:0]     ridx;
      logic [LEN_W-1:0]     rlen;
      logic                 efound;
      logic [IDX_W-1:0]     eidx;
   } probe_type;

   typedef struct packed {
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_idx;
      logic [ADDR_BITS-1:0] wr_base;
      logic [LEN_W-1:0]     wr_len;
      logic                 clr_en;
      logic [IDX_W-1:0]     clr_idx;
   } upd_type;

endpackage

[sv/fsba_req_if.sv]
// Request channel of the fit strategy block allocator.
// Depends on fsba_pkg for field widths.
interface fsba_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [fsba_pkg::ADDR_BITS-1:0] req_size;
   logic [fsba_pkg::ADDR_BITS-1:0] free_addr;

   modport source (output valid, action, req_size, free_addr, input ready);
   modport sink (input valid, action, req_size, free_addr, output ready);
endinterface

[sv/fsba_rsp_if.sv]
// Response channel of the fit strategy block allocator.
// Depends on fsba_pkg for field widths.
interface fsba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fsba_pkg::ADDR_BITS-1:0] block_addr;
   logic [1:0]                    status;

   modport source (output valid, block_addr, status, input ready);
   modport sink (input valid, block_addr, status, output ready);
endinterface

[sv/fsba_cell.sv]
// One free-table entry and its compare stage in the probe chain.
// Depends on fsba_pkg.
module fsba_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [fsba_pkg::IDX_W-1:0]     cell_idx,
   input  fsba_pkg::probe_type            probe_in,
   input  fsba_pkg::upd_type              upd,
   output fsba_pkg::probe_type            probe_out
);

   logic [fsba_pkg::ADDR_BITS-1:0] base_ff;
   logic [fsba_pkg::LEN_W-1:0]     len_ff;
   logic                           valid_ff;
   fsba_pkg::probe_type            probe_ff, probe_in_c;

   logic                       fits, take, left_hit, right_hit;
   logic [fsba_pkg::LEN_W:0]   top_sum;

   always_comb begin
      probe_in_c = probe_in;
      fits = valid_ff && (len_ff >= fsba_pkg::LEN_W'(probe_in.size));
      top_sum = (fsba_pkg::LEN_W+1)'(base_ff) + (fsba_pkg::LEN_W+1)'(len_ff);
      left_hit = valid_ff && !probe_in.lfound &&
                 (top_sum == (fsba_pkg::LEN_W+1)'(probe_in.addr));
      right_hit = valid_ff && !probe_in.rfound &&
                  (fsba_pkg::LEN_W'(base_ff) == probe_in.end_a);
      take = 1'b0;
      if (fits) begin
         if (!probe_in.bfound) begin
            take = 1'b1;
         end else begin
            case (probe_in.strat)
               fsba_pkg::FIT_BEST: take = (len_ff < probe_in.blen) ||
                  ((len_ff == probe_in.blen) && (base_ff < probe_in.bbase));
               fsba_pkg::FIT_WORST: take = (len_ff > probe_in.blen) ||
                  ((len_ff == probe_in.blen) && (base_ff < probe_in.bbase));
               default: take = base_ff < probe_in.bbase;
            endcase
         end
      end
      if (probe_in.act == fsba_pkg::ACT_ALLOC) begin
         if (take) begin
            probe_in_c.bfound = 1'b1;
            probe_in_c.bidx   = cell_idx;
            probe_in_c.bbase  = base_ff;
            probe_in_c.blen   = len_ff;
         end
      end else begin
         if (!valid_ff && !probe_in.efound) begin
            probe_in_c.efound = 1'b1;
            probe_in_c.eidx   = cell_idx;
         end
         if (left_hit) begin
            probe_in_c.lfound = 1'b1;
            probe_in_c.lidx   = cell_idx;
            probe_in_c.lbase  = base_ff;
            probe_in_c.llen   = len_ff;
         end
         if (right_hit) begin
            probe_in_c.rfound = 1'b1;
            probe_in_c.ridx   = cell_idx;
            probe_in_c.rlen   = len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_c;
      end
      if (upd.wr_en && (upd.wr_idx == cell_idx)) begin
         base_ff <= upd.wr_base;
         len_ff  <= upd.wr_len;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (upd.clr_en && (upd.clr_idx == cell_idx)) begin
         valid_ff <= 1'b0;
      end else if (upd.wr_en && (upd.wr_idx == cell_idx)) begin
         valid_ff <= 1'b1;
      end
   end

   assign probe_out = probe_ff;

endmodule

[sv/fit_strategy_block_allocator.sv]
// Fit strategy block allocator: request handling, heap top and table update.
// Depends on fsba_pkg, fsba_req_if, fsba_rsp_if, fsba_cell and the defines header.
//
// Usage:
//   req channel carries action (0 allocate, 1 free), req_size and free_addr.
//   rsp channel returns block_addr and status, one item per request.
//   csr port: csr_we writes csr_wdata to register csr_idx
//   (0 fit strategy, 1 heap limit); write only while the block is idle.
// Operation:
//   A request sends one probe down a chain of 64 table cells, one cell per
//   cycle; the result and the table update follow at the chain end.
//   One item is in flight at a time; the next request is taken only once
//   the result of the last one has moved into the rsp register.
// Reset:
//   All table entries become empty, heap top goes to zero, fit strategy to
//   first fit and the heap limit to 65536. No clearing pass is needed.
// Stall:
//   A result waits in the rsp register; a finished result behind it is held
//   in a pending register and no new item is taken until it moves on.
`include "fit_strategy_block_allocator_defines.svh"

module fit_strategy_block_allocator (
   input  logic                       clock,
   input  logic                       reset,
   fsba_req_if.sink                   req,
   fsba_rsp_if.source                 rsp,
   input  logic                       csr_we,
   input  logic                       csr_idx,
   input  logic [fsba_pkg::LEN_W-1:0] csr_wdata
);

   logic [1:0]                 fit_ff;
   logic [fsba_pkg::LEN_W-1:0] limit_ff;
   logic [fsba_pkg::LEN_W-1:0] heap_top_ff, heap_top_in;
   logic                       busy_ff;
   logic                       pend_ff, pend_in;
   logic [fsba_pkg::ADDR_BITS-1:0] pend_addr_ff, pend_addr_in;
   logic [1:0]                 pend_st_ff, pend_st_in;
   logic                       rsp_valid_ff;
   logic [fsba_pkg::ADDR_BITS-1:0] rsp_addr_ff;
   logic [1:0]                 rsp_st_ff;

   fsba_pkg::probe_type chain [0:fsba_pkg::FREE_ENTRIES];
   fsba_pkg::probe_type done;
   fsba_pkg::upd_type   upd;

   logic                       accept, out_free;
   logic [fsba_pkg::LEN_W-1:0] limit, size_x;
   logic [fsba_pkg::LEN_W:0]   ext_sum;
   logic [fsba_pkg::ADDR_BITS-1:0] res_addr;
   logic [1:0]                 res_st;

   assign accept    = req.valid && req.ready;
   assign req.ready = !busy_ff;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      chain[0]        = '0;
      chain[0].vld    = accept;
      chain[0].act    = req.action;
      chain[0].size   = req.req_size;
      chain[0].addr   = req.free_addr;
      chain[0].end_a  = fsba_pkg::LEN_W'(req.free_addr) + fsba_pkg::LEN_W'(req.req_size);
      chain[0].strat  = fit_ff;
   end

   for (genvar i = 0; i < fsba_pkg::FREE_ENTRIES; i++) begin : g_cell
      fsba_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (fsba_pkg::IDX_W'(i)),
         .probe_in  (chain[i]),
         .upd       (upd),
         .probe_out (chain[i+1])
      );
   end

   assign done = chain[fsba_pkg::FREE_ENTRIES];

   always_comb begin
      upd         = '0;
      heap_top_in = heap_top_ff;
      res_addr    = '0;
      res_st      = fsba_pkg::ST_OOM;
      size_x      = fsba_pkg::LEN_W'(done.size);
      limit       = (limit_ff > fsba_pkg::ADDR_SPACE) ? fsba_pkg::ADDR_SPACE : limit_ff;
      ext_sum     = (fsba_pkg::LEN_W+1)'(heap_top_ff) + (fsba_pkg::LEN_W+1)'(done.size);
      if (done.vld) begin
         if (done.act == fsba_pkg::ACT_ALLOC) begin
            if (done.size == '0) begin
               res_st = fsba_pkg::ST_OOM;
            end else if (done.bfound) begin
               res_addr = done.bbase;
               res_st   = fsba_pkg::ST_OK;
               if (done.blen == size_x) begin
                  upd.clr_en  = 1'b1;
                  upd.clr_idx = done.bidx;
               end else begin
                  upd.wr_en   = 1'b1;
                  upd.wr_idx  = done.bidx;
                  upd.wr_base = done.bbase + done.size;
                  upd.wr_len  = done.blen - size_x;
               end
            end else if (ext_sum <= (fsba_pkg::LEN_W+1)'(limit)) begin
               res_addr    = heap_top_ff[fsba_pkg::ADDR_BITS-1:0];
               res_st      = fsba_pkg::ST_HEAP;
               heap_top_in = ext_sum[fsba_pkg::LEN_W-1:0];
            end
         end else begin
            res_st = fsba_pkg::ST_OK;
            if ((done.size == '0) || (done.end_a > heap_top_ff)) begin
               res_st = fsba_pkg::ST_OOM;
            end else if (done.lfound) begin
               upd.wr_en   = 1'b1;
               upd.wr_idx  = done.lidx;
               upd.wr_base = done.lbase;
               upd.wr_len  = done.llen + size_x + (done.rfound ? done.rlen : '0);
               upd.clr_en  = done.rfound;
               upd.clr_idx = done.ridx;
            end else if (done.rfound) begin
               upd.wr_en   = 1'b1;
               upd.wr_idx  = done.ridx;
               upd.wr_base = done.addr;
               upd.wr_len  = done.rlen + size_x;
            end else if (done.efound) begin
               upd.wr_en   = 1'b1;
               upd.wr_idx  = done.eidx;
               upd.wr_base = done.addr;
               upd.wr_len  = size_x;
            end else begin
               res_st = fsba_pkg::ST_FULL;
            end
         end
      end
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      pend_st_in   = pend_st_ff;
      if (done.vld) begin
         pend_in      = 1'b1;
         pend_addr_in = res_addr;
         pend_st_in   = res_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_ff       <= fsba_pkg::FIT_FIRST;
         limit_ff     <= fsba_pkg::ADDR_SPACE;
         heap_top_ff  <= '0;
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_idx == fsba_pkg::CSR_FIT)) begin
            fit_ff <= csr_wdata[1:0];
         end
         if (csr_we && (csr_idx == fsba_pkg::CSR_LIMIT)) begin
            limit_ff <= csr_wdata;
         end
         heap_top_ff <= heap_top_in;
         if (pend_in && out_free) begin
            rsp_valid_ff <= 1'b1;
            pend_ff      <= 1'b0;
            busy_ff      <= 1'b0;
         end else begin
            if (rsp_valid_ff && rsp.ready) begin
               rsp_valid_ff <= 1'b0;
            end
            pend_ff <= pend_in;
            if (accept) begin
               busy_ff <= 1'b1;
            end
         end
      end
      pend_addr_ff <= pend_addr_in;
      pend_st_ff   <= pend_st_in;
      if (pend_in && out_free) begin
         rsp_addr_ff <= pend_addr_in;
         rsp_st_ff   <= pend_st_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.block_addr = rsp_addr_ff;
   assign rsp.status     = rsp_st_ff;

   `FSBA_ASSERT_NEXT(a_accept_busy, accept, busy_ff, "accepted item did not mark busy")
   `FSBA_ASSERT_NOW(a_done_busy, done.vld, busy_ff && !pend_ff, "probe finished while idle")
   `FSBA_ASSERT_NOW(a_top_bound, 1'b1, heap_top_ff <= fsba_pkg::ADDR_SPACE, "heap top overflow")

endmodule

[verif/tb.sv]
// Self-checking testbench for the fit strategy block allocator.
// Depends on fsba_pkg, fsba_req_if, fsba_rsp_if and the allocator RTL;
// predicts each grant or free status from its own copy of the free table.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                           act;
      logic [fsba_pkg::ADDR_BITS-1:0] size;
      logic [fsba_pkg::ADDR_BITS-1:0] addr;
   } req_item_type;

   typedef struct {
      logic [fsba_pkg::ADDR_BITS-1:0] baddr;
      logic [1:0]                     status;
   } rsp_item_type;

   typedef struct {
      int base;
      int len;
   } span_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic                       csr_idx = fsba_pkg::CSR_FIT;
   logic [fsba_pkg::LEN_W-1:0] csr_wdata = '0;

   fsba_req_if req ();
   fsba_rsp_if rsp ();

   fit_strategy_block_allocator dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   span_type     live_blocks[$];

   int         tbl_base[fsba_pkg::FREE_ENTRIES];
   int         tbl_len[fsba_pkg::FREE_ENTRIES];
   bit         tbl_vld[fsba_pkg::FREE_ENTRIES];
   int         heap_top = 0;
   logic [1:0] strategy = fsba_pkg::FIT_FIRST;
   int         limit = 65536;

   int   errors = 0;
   bit   req_fire = 1'b0;
   bit   idle_free = 1'b0;
   int   cycle = 0;

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.action = fsba_pkg::ACT_ALLOC;
      req.req_size = '0;
      req.free_addr = '0;
      rsp.ready = 1'b0;
   end

   function automatic bit stall_now();
      return !idle_free && ($urandom_range(0, 99) < 17);
   endfunction

   // quiet stretch without idling early in the run
   always @(posedge clock) begin
      cycle <= cycle + 1;
      idle_free <= (cycle > 8000 && cycle < 20000);
      req_fire <= req.valid && req.ready;
   end

   always @(negedge clock) begin
      req_item_type r;
      if (!reset) begin
         rsp.ready <= !stall_now();
         if (!req.valid || req_fire) begin
            if (pending_reqs.size() > 0 && !stall_now()) begin
               r = pending_reqs.pop_front();
               req.action <= r.act;
               req.req_size <= r.size;
               req.free_addr <= r.addr;
               req.valid <= 1'b1;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected item addr=%h status=%0d", $time,
                     rsp.block_addr, rsp.status);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp.block_addr !== e.baddr) begin
               $display("%0t: block_addr expected %h actual %h", $time,
                        e.baddr, rsp.block_addr);
               errors++;
            end
            if (rsp.status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        e.status, rsp.status);
               errors++;
            end
         end
      end
   end

   function automatic rsp_item_type grant_block(int size);
      rsp_item_type o;
      int           k;
      bit           take;
      int           cap;
      o.baddr = '0;
      o.status = fsba_pkg::ST_OOM;
      if (size == 0) return o;
      k = -1;
      for (int i = 0; i < fsba_pkg::FREE_ENTRIES; i++) begin
         if (!tbl_vld[i] || tbl_len[i] < size) continue;
         if (k < 0) begin
            k = i;
            continue;
         end
         if (strategy == fsba_pkg::FIT_BEST)
            take = tbl_len[i] < tbl_len[k] ||
                   (tbl_len[i] == tbl_len[k] && tbl_base[i] < tbl_base[k]);
         else if (strategy == fsba_pkg::FIT_WORST)
            take = tbl_len[i] > tbl_len[k] ||
                   (tbl_len[i] == tbl_len[k] && tbl_base[i] < tbl_base[k]);
         else
            take = tbl_base[i] < tbl_base[k];
         if (take) k = i;
      end
      if (k >= 0) begin
         o.baddr = fsba_pkg::ADDR_BITS'(tbl_base[k]);
         if (tbl_len[k] == size) tbl_vld[k] = 1'b0;
         else begin
            tbl_base[k] = (tbl_base[k] + size) & 16'hFFFF;
            tbl_len[k] -= size;
         end
         o.status = fsba_pkg::ST_OK;
         return o;
      end
      cap = (limit < 65536) ? limit : 65536;
      if (heap_top + size <= cap) begin
         o.baddr = fsba_pkg::ADDR_BITS'(heap_top & 16'hFFFF);
         heap_top += size;
         o.status = fsba_pkg::ST_HEAP;
      end
      return o;
   endfunction

   function automatic logic [1:0] release_block(int addr, int size);
      int stop;
      int left;
      int right;
      int empty;
      stop = addr + size;
      left = -1;
      right = -1;
      empty = -1;
      if (size == 0 || stop > heap_top) return fsba_pkg::ST_OOM;
      for (int i = 0; i < fsba_pkg::FREE_ENTRIES; i++) begin
         if (!tbl_vld[i]) begin
            if (empty < 0) empty = i;
            continue;
         end
         if (left < 0 && tbl_base[i] + tbl_len[i] == addr) left = i;
         if (right < 0 && tbl_base[i] == stop) right = i;
      end
      if (left >= 0 && right >= 0) begin
         tbl_len[left] += size + tbl_len[right];
         tbl_vld[right] = 1'b0;
      end else if (left >= 0) begin
         tbl_len[left] += size;
      end else if (right >= 0) begin
         tbl_base[right] = addr;
         tbl_len[right] += size;
      end else if (empty >= 0) begin
         tbl_base[empty] = addr;
         tbl_len[empty] = size;
         tbl_vld[empty] = 1'b1;
      end else begin
         return fsba_pkg::ST_FULL;
      end
      return fsba_pkg::ST_OK;
   endfunction

   task automatic send(logic act, int size, int addr);
      req_item_type r;
      rsp_item_type o;
      span_type     s;
      r.act = act;
      r.size = fsba_pkg::ADDR_BITS'(size);
      r.addr = fsba_pkg::ADDR_BITS'(addr);
      if (act == fsba_pkg::ACT_ALLOC) begin
         o = grant_block(int'(r.size));
         if (o.status == fsba_pkg::ST_OK || o.status == fsba_pkg::ST_HEAP) begin
            s.base = int'(o.baddr);
            s.len = int'(r.size);
            live_blocks.insert(live_blocks.size(), s);
         end
      end else begin
         o.baddr = '0;
         o.status = release_block(int'(r.addr), int'(r.size));
      end
      pending_reqs.insert(pending_reqs.size(), r);
      expected_rsps.insert(expected_rsps.size(), o);
   endtask

   task automatic free_live(int idx);
      span_type s;
      s = live_blocks[idx];
      live_blocks.delete(idx);
      send(fsba_pkg::ACT_FREE, s.len, s.base);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= fsba_pkg::LEN_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == fsba_pkg::CSR_FIT) strategy = 2'(value & 3);
      else limit = value & 17'h1FFFF;
   endtask

   task automatic random_phase(int count);
      int p;
      for (int n = 0; n < count; n++) begin
         p = $urandom_range(0, 99);
         if (p < 65) send(fsba_pkg::ACT_ALLOC, $urandom_range(1, 64), 0);
         else if (p < 70) send(fsba_pkg::ACT_ALLOC, $urandom_range(0, 65535), 0);
         else if (p < 93 && live_blocks.size() > 0)
            free_live($urandom_range(0, live_blocks.size() - 1));
         else send(fsba_pkg::ACT_FREE, $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
      end
   endtask

   initial begin
      int mark;
      for (int i = 0; i < fsba_pkg::FREE_ENTRIES; i++) tbl_vld[i] = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(fsba_pkg::ACT_ALLOC, 0, 0);
      send(fsba_pkg::ACT_FREE, 4, 0);
      for (int i = 1; i <= 6; i++) send(fsba_pkg::ACT_ALLOC, i * 8, 16'hFFFF);
      send(fsba_pkg::ACT_ALLOC, 65535, 0);
      send(fsba_pkg::ACT_FREE, 0, 8);
      send(fsba_pkg::ACT_FREE, 65535, 65535);
      free_live(1);
      free_live(2);
      send(fsba_pkg::ACT_FREE, 24, 8);
      free_live(0);
      send(fsba_pkg::ACT_ALLOC, 4, 0);
      drain();
      write_csr(fsba_pkg::CSR_FIT, int'(fsba_pkg::FIT_BEST));
      send(fsba_pkg::ACT_ALLOC, 4, 0);
      drain();
      write_csr(fsba_pkg::CSR_FIT, int'(fsba_pkg::FIT_WORST));
      send(fsba_pkg::ACT_ALLOC, 4, 0);
      drain();
      write_csr(fsba_pkg::CSR_FIT, 3);
      write_csr(fsba_pkg::CSR_LIMIT, 1);
      send(fsba_pkg::ACT_ALLOC, 200, 0);
      send(fsba_pkg::ACT_ALLOC, 2, 0);
      drain();
      write_csr(fsba_pkg::CSR_LIMIT, 17'h1FFFF);

      for (int ph = 0; ph < 4; ph++) begin
         write_csr(fsba_pkg::CSR_FIT, ph);
         write_csr(fsba_pkg::CSR_LIMIT,
                   (ph == 2) ? 40000 : ((ph == 1) ? 65536 : 17'h1FFFF));
         random_phase(130);
         drain();
      end

      write_csr(fsba_pkg::CSR_FIT, int'(fsba_pkg::FIT_FIRST));
      write_csr(fsba_pkg::CSR_LIMIT, 65536);
      mark = live_blocks.size();
      for (int i = 0; i < 150; i++) send(fsba_pkg::ACT_ALLOC, 1, 0);
      for (int i = 0; i < 75; i++)
         if (mark + i < live_blocks.size()) free_live(mark + i);
      drain();
      write_csr(fsba_pkg::CSR_FIT, int'(fsba_pkg::FIT_BEST));
      random_phase(40);
      drain();

      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

[sim.f]
+incdir+sv
sv/fsba_pkg.sv
sv/fsba_req_if.sv
sv/fsba_rsp_if.sv
sv/fsba_cell.sv
sv/fit_strategy_block_allocator.sv
verif/tb.sv
